>>> src/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg
// Types, constants and numeral tables shared by the integer-to-Roman core.
// ----------------------------------------------------------------------------
`default_nettype none

package irn_pkg;

    localparam int VALUE_W     = 12;
    localparam int SYMBOL_W    = 7;
    localparam int STEP_W      = 4;
    localparam int NUM_ENTRIES = 13;
    localparam int MAX_VALID   = 3999;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

    typedef struct packed {
        logic               err;
        logic [VALUE_W-1:0] value;
    } t_job;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    function automatic logic [VALUE_W-1:0] weight(input logic [STEP_W-1:0] step);
        logic [VALUE_W-1:0] w;
        case (step)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    function automatic logic [SYMBOL_W-1:0] lead_sym(input logic [STEP_W-1:0] step);
        logic [SYMBOL_W-1:0] s;
        case (step)
            4'd0:    s = SYM_M;
            4'd1:    s = SYM_C;
            4'd2:    s = SYM_D;
            4'd3:    s = SYM_C;
            4'd4:    s = SYM_C;
            4'd5:    s = SYM_X;
            4'd6:    s = SYM_L;
            4'd7:    s = SYM_X;
            4'd8:    s = SYM_X;
            4'd9:    s = SYM_I;
            4'd10:   s = SYM_V;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    function automatic logic [SYMBOL_W-1:0] tail_sym(input logic [STEP_W-1:0] step);
        logic [SYMBOL_W-1:0] s;
        case (step)
            4'd1:    s = SYM_M;
            4'd3:    s = SYM_D;
            4'd5:    s = SYM_C;
            4'd7:    s = SYM_L;
            4'd9:    s = SYM_X;
            4'd11:   s = SYM_V;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/irn_channels.sv
// ----------------------------------------------------------------------------
// irn_channels
// Valid/ready channels for integer input and numeral character output.
// ----------------------------------------------------------------------------
`default_nettype none

interface irn_in_if;
    logic                        valid;
    logic                        ready;
    logic [irn_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface irn_out_if;
    logic                         valid;
    logic                         ready;
    logic [irn_pkg::SYMBOL_W-1:0] symbol;
    logic                         last;
    logic                         error;

    modport source (output valid, output symbol, output last, output error, input ready);
    modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

`default_nettype wire

>>> src/irn_front.sv
// ----------------------------------------------------------------------------
// irn_front
// Accept input transactions, range-check the value and hold one classified job.
// ----------------------------------------------------------------------------
`default_nettype none

module irn_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    irn_in_if.sink             i_in,
    output      logic          o_job_valid,
    input  wire logic          i_job_ready,
    output      irn_pkg::t_job o_job
);

    logic          r_valid;
    irn_pkg::t_job r_job;
    logic          in_take;
    logic          bad;

    assign i_in.ready = !r_valid || i_job_ready;
    assign in_take    = i_in.valid && i_in.ready;
    assign bad        = (i_in.value == '0) ||
                        (i_in.value > irn_pkg::VALUE_W'(irn_pkg::MAX_VALID));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_take) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_job.err   <= bad;
            r_job.value <= i_in.value;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

`default_nettype wire

>>> src/irn_queue.sv
// ----------------------------------------------------------------------------
// irn_queue
// Short job queue between the front and the back of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module irn_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output      logic          o_push_ready,
    input  wire irn_pkg::t_job i_push_job,
    output      logic          o_pop_valid,
    input  wire logic          i_pop_ready,
    output      irn_pkg::t_job o_pop_job
);

    localparam logic [irn_pkg::QUEUE_AW-1:0] LAST_PTR =
        irn_pkg::QUEUE_AW'(irn_pkg::QUEUE_DEPTH - 1);
    localparam logic [irn_pkg::QUEUE_CW-1:0] FULL_CNT =
        irn_pkg::QUEUE_CW'(irn_pkg::QUEUE_DEPTH);

    irn_pkg::t_job                 r_mem [irn_pkg::QUEUE_DEPTH];
    logic [irn_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [irn_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [irn_pkg::QUEUE_CW-1:0]  r_count;
    logic                          push;
    logic                          pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_job    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

>>> src/irn_back.sv
// ----------------------------------------------------------------------------
// irn_back
// Greedy-subtraction sequencer: one numeral character per output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module irn_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    output      logic          o_job_ready,
    input  wire irn_pkg::t_job i_job,
    irn_out_if.source          o_out
);

    irn_pkg::t_back_state          r_state;
    irn_pkg::t_back_state          n_state;
    logic [irn_pkg::VALUE_W-1:0]   r_rem;
    logic [irn_pkg::VALUE_W-1:0]   n_rem;
    logic [irn_pkg::STEP_W-1:0]    r_step;
    logic [irn_pkg::STEP_W-1:0]    n_step;
    logic                          r_pend;
    logic                          n_pend;
    logic                          r_out_valid;
    logic [irn_pkg::SYMBOL_W-1:0]  r_sym;
    logic                          r_last;
    logic                          r_err;

    logic                          can_emit;
    logic                          pop;
    logic                          emit;
    logic [irn_pkg::SYMBOL_W-1:0]  e_sym;
    logic                          e_last;
    logic                          e_err;
    logic [irn_pkg::VALUE_W-1:0]   w;
    logic [irn_pkg::VALUE_W-1:0]   diff;
    logic [irn_pkg::SYMBOL_W-1:0]  tail;

    assign can_emit = !r_out_valid || o_out.ready;
    assign w        = irn_pkg::weight(r_step);
    assign diff     = r_rem - w;
    assign tail     = irn_pkg::tail_sym(r_step);

    always_comb begin
        n_state = r_state;
        case (r_state)
            irn_pkg::BK_IDLE: begin
                if (pop && !i_job.err) n_state = irn_pkg::BK_RUN;
            end
            irn_pkg::BK_RUN: begin
                if (emit && e_last) n_state = irn_pkg::BK_IDLE;
            end
            default: n_state = irn_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop    = 1'b0;
        emit   = 1'b0;
        e_sym  = irn_pkg::SYM_NONE;
        e_last = 1'b0;
        e_err  = 1'b0;
        n_rem  = r_rem;
        n_step = r_step;
        n_pend = r_pend;
        case (r_state)
            irn_pkg::BK_IDLE: begin
                if (i_job_valid && can_emit) begin
                    pop = 1'b1;
                    if (i_job.err) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_err  = 1'b1;
                    end else begin
                        n_rem  = i_job.value;
                        n_step = '0;
                        n_pend = 1'b0;
                    end
                end
            end
            irn_pkg::BK_RUN: begin
                if (r_pend) begin
                    if (can_emit) begin
                        emit   = 1'b1;
                        e_sym  = tail;
                        e_last = (diff == '0);
                        n_pend = 1'b0;
                        n_rem  = diff;
                    end
                end else if (r_rem >= w) begin
                    if (can_emit) begin
                        emit  = 1'b1;
                        e_sym = irn_pkg::lead_sym(r_step);
                        if (tail != irn_pkg::SYM_NONE) begin
                            n_pend = 1'b1;
                        end else begin
                            n_rem  = diff;
                            e_last = (diff == '0);
                        end
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= irn_pkg::BK_IDLE;
            r_step      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pend  <= n_pend;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (emit) begin
            r_sym  <= e_sym;
            r_last <= e_last;
            r_err  <= e_err;
        end
    end

    assign o_job_ready  = pop;
    assign o_out.valid  = r_out_valid;
    assign o_out.symbol = r_sym;
    assign o_out.last   = r_last;
    assign o_out.error  = r_err;

endmodule

`default_nettype wire

>>> src/integer_to_roman_numeral_core.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_core
// Converts integers 1..3999 to Roman numerals, one ASCII letter per output.
// ----------------------------------------------------------------------------
//  port     dir  payload                     role
//  i_in     in   value[11:0]                 integer to convert
//  o_out    out  symbol[6:0], last, error    one letter, or one error marker
//
//  A valid value is loaded into the single greedy-subtraction sequencer in
//  the back, which emits one letter at a time and passes over table entries
//  that do not fit. An out-of-range value gives a lone error marker.
//  Reset (i_rst_n low, synchronous) empties the job queue and output register.
//  A stalled output holds the sequencer; the front and its two-entry queue
//  keep taking values meanwhile, until both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_roman_numeral_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    irn_in_if.sink    i_in,
    irn_out_if.source o_out
);

    logic          front_valid;
    logic          front_ready;
    irn_pkg::t_job front_job;
    logic          queue_valid;
    logic          queue_ready;
    irn_pkg::t_job queue_job;

    irn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    irn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_job    (queue_job)
    );

    irn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .o_job_ready (queue_ready),
        .i_job       (queue_job),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> src/irn_checker.sv
// ----------------------------------------------------------------------------
// irn_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module irn_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [irn_pkg::SYMBOL_W-1:0] i_out_symbol,
    input wire logic                         i_out_last,
    input wire logic                         i_out_error
);

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_error) |->
            (i_out_symbol == irn_pkg::SYM_NONE) && i_out_last)
        else $error("error transaction not a lone zero symbol");

    a_letter_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_error) |->
            (i_out_symbol == irn_pkg::SYM_I) || (i_out_symbol == irn_pkg::SYM_V) ||
            (i_out_symbol == irn_pkg::SYM_X) || (i_out_symbol == irn_pkg::SYM_L) ||
            (i_out_symbol == irn_pkg::SYM_C) || (i_out_symbol == irn_pkg::SYM_D) ||
            (i_out_symbol == irn_pkg::SYM_M))
        else $error("letter transaction with a non-numeral symbol");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_out_symbol) && $stable(i_out_last) &&
            $stable(i_out_error))
        else $error("stalled output transaction changed");

endmodule

bind integer_to_roman_numeral_core irn_checker u_irn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.symbol),
    .i_out_last   (o_out.last),
    .i_out_error  (o_out.error)
);

`default_nettype wire
